@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define FGP_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define FGP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define FGP_ASSERT(label, prop)
`define FGP_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ hw/rtl/fgp_pkg.sv @@
// ----------------------------------------------------------------------------
// fgp_pkg
// Shared types and constants of the fire grid propagation block.
// ----------------------------------------------------------------------------
package fgp_pkg;

    localparam int FUNC_W   = 3;
    localparam int HEAT_W   = 7;
    localparam int PIX_W    = 12;
    localparam int RAND_W   = 15;
    localparam int IDX_W    = 6;
    localparam int CFG_W    = 7;
    localparam int CFG_IX_W = 3;
    localparam int DEC_W    = 4;
    localparam int DIV_W    = 7;
    localparam int DCNT_W   = 4;
    localparam int LANES    = 2;

    // x / 100 as (x * 5243) >> 19, exact for 15-bit x
    localparam int PCT_RECIP_W = 13;
    localparam int PCT_SHIFT   = 19;
    localparam int PROD_W      = RAND_W + PCT_RECIP_W;
    localparam int PQ_W        = PROD_W - PCT_SHIFT;

    localparam logic [DIV_W-1:0]       PCT_RANGE = 7'd100;
    localparam logic [PCT_RECIP_W-1:0] PCT_RECIP = 13'd5243;
    localparam logic [DCNT_W-1:0]      DIV_STEPS = 4'd15;

    localparam logic [FUNC_W-1:0] F_PROP  = 3'd0;
    localparam logic [FUNC_W-1:0] F_READ  = 3'd1;
    localparam logic [FUNC_W-1:0] F_BRUSH = 3'd2;
    localparam logic [FUNC_W-1:0] F_HOT   = 3'd3;
    localparam logic [FUNC_W-1:0] F_CLEAR = 3'd4;
    localparam logic [FUNC_W-1:0] F_ZERO  = 3'd5;
    localparam logic [FUNC_W-1:0] F_RSVD6 = 3'd6;
    localparam logic [FUNC_W-1:0] F_RSVD7 = 3'd7;

    localparam logic [CFG_IX_W-1:0] REG_GRID_WIDTH  = 3'd0;
    localparam logic [CFG_IX_W-1:0] REG_GRID_HEIGHT = 3'd1;
    localparam logic [CFG_IX_W-1:0] REG_CELL_SIZE   = 3'd2;
    localparam logic [CFG_IX_W-1:0] REG_CHANCE_UP   = 3'd3;
    localparam logic [CFG_IX_W-1:0] REG_CHANCE_LEFT = 3'd4;
    localparam logic [CFG_IX_W-1:0] REG_DECAY_UP    = 3'd5;
    localparam logic [CFG_IX_W-1:0] REG_DECAY_LEFT  = 3'd6;
    localparam logic [CFG_IX_W-1:0] REG_HOTTEST     = 3'd7;

    localparam logic [CFG_W-1:0] RST_GRID_WIDTH  = 7'd64;
    localparam logic [CFG_W-1:0] RST_GRID_HEIGHT = 7'd64;
    localparam logic [CFG_W-1:0] RST_CELL_SIZE   = 7'd8;
    localparam logic [CFG_W-1:0] RST_CHANCE_UP   = 7'd70;
    localparam logic [CFG_W-1:0] RST_CHANCE_LEFT = 7'd40;
    localparam logic [DEC_W-1:0] RST_DECAY_UP    = 4'd2;
    localparam logic [DEC_W-1:0] RST_DECAY_LEFT  = 4'd3;
    localparam logic [CFG_W-1:0] RST_HOTTEST     = 7'd36;

    localparam logic [1:0] SW_ALL   = 2'd0;
    localparam logic [1:0] SW_CLEAR = 2'd1;
    localparam logic [1:0] SW_HOT   = 2'd2;
    localparam logic [1:0] SW_ZERO  = 2'd3;

    typedef struct packed {
        logic       accept;
        logic       wrap_ptr;
        logic       div_start;
        logic       wr_up;
        logic       wr_left;
        logic       advance_ptr;
        logic       set_read;
        logic       brush_init;
        logic       brush_step;
        logic       sweep_init;
        logic [1:0] sweep_kind;
        logic       sweep_step;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              div_done;
        logic              brush_last;
        logic              sweep_last;
        logic              out_free;
    } stat_t;

endpackage

@@ hw/rtl/fgp_ram.sv @@
// ----------------------------------------------------------------------------
// fgp_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module fgp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/fgp_datapath.sv @@
// ----------------------------------------------------------------------------
// fgp_datapath
// Configuration registers, heat grid memory, scan pointer, remainder lanes,
// brush and sweep counters, and the result register.
// ----------------------------------------------------------------------------
module fgp_datapath #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64,
    localparam int CW  = $clog2(MAX_COLS),
    localparam int RW  = $clog2(MAX_ROWS),
    localparam int CCW = $clog2(MAX_COLS + 1),
    localparam int RCW = $clog2(MAX_ROWS + 1)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [fgp_pkg::CFG_IX_W-1:0]   cfg_index,
    input  logic [fgp_pkg::CFG_W-1:0]      cfg_data,
    input  logic [fgp_pkg::FUNC_W-1:0]     func,
    input  logic [fgp_pkg::PIX_W-1:0]      pixel_x,
    input  logic [fgp_pkg::PIX_W-1:0]      pixel_y,
    input  logic [fgp_pkg::IDX_W-1:0]      cell_col,
    input  logic [fgp_pkg::IDX_W-1:0]      cell_row,
    input  logic [fgp_pkg::RAND_W-1:0]     rand_up_gate,
    input  logic [fgp_pkg::RAND_W-1:0]     rand_up_drop,
    input  logic [fgp_pkg::RAND_W-1:0]     rand_left_gate,
    input  logic [fgp_pkg::RAND_W-1:0]     rand_left_drop,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [fgp_pkg::HEAT_W-1:0]     cell_value,
    output logic [fgp_pkg::IDX_W-1:0]      scan_col,
    output logic [fgp_pkg::IDX_W-1:0]      scan_row,
    output logic                           frame_done,
    input  fgp_pkg::cmd_t                  cmd,
    output fgp_pkg::stat_t                 stat
);
    import fgp_pkg::*;

    localparam int AW = RW + CW;
    localparam int SW = 14;
    localparam logic [2:0] BR_LAST = 3'd4;

    // configuration
    logic [CFG_W-1:0] gw_reg, gh_reg, cs_reg, cu_reg, cl_reg, hot_reg;
    logic [DEC_W-1:0] du_reg, dl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gw_reg  <= RST_GRID_WIDTH;
            gh_reg  <= RST_GRID_HEIGHT;
            cs_reg  <= RST_CELL_SIZE;
            cu_reg  <= RST_CHANCE_UP;
            cl_reg  <= RST_CHANCE_LEFT;
            du_reg  <= RST_DECAY_UP;
            dl_reg  <= RST_DECAY_LEFT;
            hot_reg <= RST_HOTTEST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_GRID_WIDTH:  gw_reg  <= cfg_data;
                REG_GRID_HEIGHT: gh_reg  <= cfg_data;
                REG_CELL_SIZE:   cs_reg  <= cfg_data;
                REG_CHANCE_UP:   cu_reg  <= cfg_data;
                REG_CHANCE_LEFT: cl_reg  <= cfg_data;
                REG_DECAY_UP:    du_reg  <= cfg_data[DEC_W-1:0];
                REG_DECAY_LEFT:  dl_reg  <= cfg_data[DEC_W-1:0];
                REG_HOTTEST:     hot_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    logic [CCW-1:0]   w_eff;
    logic [RCW-1:0]   h_eff;
    logic [DIV_W-1:0] cs_eff, du_eff, dl_eff;

    assign w_eff  = (gw_reg == '0) ? CCW'(1) :
                    (gw_reg > MAX_COLS) ? CCW'(MAX_COLS) : CCW'(gw_reg);
    assign h_eff  = (gh_reg == '0) ? RCW'(1) :
                    (gh_reg > MAX_ROWS) ? RCW'(MAX_ROWS) : RCW'(gh_reg);
    assign cs_eff = (cs_reg == '0) ? DIV_W'(1) : cs_reg;
    assign du_eff = (du_reg == '0) ? DIV_W'(1) : DIV_W'(du_reg);
    assign dl_eff = (dl_reg == '0) ? DIV_W'(1) : DIV_W'(dl_reg);

    // input word
    logic [FUNC_W-1:0] func_reg;
    logic [PIX_W-1:0]  px_reg, py_reg;
    logic [IDX_W-1:0]  ccol_reg, crow_reg;
    logic [RAND_W-1:0] rug_reg, rud_reg, rlg_reg, rld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            func_reg <= F_PROP;
        end
        else if (cmd.accept)
        begin
            func_reg <= func;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            px_reg   <= pixel_x;
            py_reg   <= pixel_y;
            ccol_reg <= cell_col;
            crow_reg <= cell_row;
            rug_reg  <= rand_up_gate;
            rud_reg  <= rand_up_drop;
            rlg_reg  <= rand_left_gate;
            rld_reg  <= rand_left_drop;
        end
    end

    // percent gates: quotient by reciprocal, remainder from the registered quotient
    logic [PROD_W-1:0] prod_up, prod_left;
    logic [PQ_W-1:0]   pq_up_reg, pq_left_reg;
    logic [RAND_W-1:0] pct_up, pct_left;

    assign prod_up   = PROD_W'(rug_reg) * PROD_W'(PCT_RECIP);
    assign prod_left = PROD_W'(rlg_reg) * PROD_W'(PCT_RECIP);

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            pq_up_reg   <= prod_up[PROD_W-1:PCT_SHIFT];
            pq_left_reg <= prod_left[PROD_W-1:PCT_SHIFT];
        end
    end

    assign pct_up   = rug_reg - RAND_W'(pq_up_reg) * RAND_W'(PCT_RANGE);
    assign pct_left = rlg_reg - RAND_W'(pq_left_reg) * RAND_W'(PCT_RANGE);

    // remainder lanes, one bit per cycle
    logic [RAND_W-1:0] dvd_reg [LANES];
    logic [RAND_W-1:0] quo_reg [LANES];
    logic [DIV_W-1:0]  dsr_reg [LANES];
    logic [DIV_W-1:0]  rem_reg [LANES];
    logic [DCNT_W-1:0] dcnt_reg;
    logic [RAND_W-1:0] dvd_ld  [LANES];
    logic [DIV_W-1:0]  dsr_ld  [LANES];
    logic [DIV_W:0]    trial   [LANES];
    logic              ge      [LANES];
    logic              is_brush;

    assign is_brush = (func_reg == F_BRUSH);

    always_comb
    begin
        dvd_ld[0] = is_brush ? RAND_W'(px_reg) : rud_reg;
        dvd_ld[1] = is_brush ? RAND_W'(py_reg) : rld_reg;
        dsr_ld[0] = is_brush ? cs_eff : du_eff;
        dsr_ld[1] = is_brush ? cs_eff : dl_eff;
        for (int i = 0; i < LANES; i++)
        begin
            trial[i] = {rem_reg[i], dvd_reg[i][RAND_W-1]};
            ge[i]    = (trial[i] >= {1'b0, dsr_reg[i]});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dcnt_reg <= '0;
        end
        else if (cmd.div_start)
        begin
            dcnt_reg <= DIV_STEPS;
        end
        else if (dcnt_reg != '0)
        begin
            dcnt_reg <= dcnt_reg - DCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < LANES; i++)
        begin
            if (cmd.div_start)
            begin
                dvd_reg[i] <= dvd_ld[i];
                dsr_reg[i] <= dsr_ld[i];
                rem_reg[i] <= '0;
                quo_reg[i] <= '0;
            end
            else if (dcnt_reg != '0)
            begin
                dvd_reg[i] <= {dvd_reg[i][RAND_W-2:0], 1'b0};
                quo_reg[i] <= {quo_reg[i][RAND_W-2:0], ge[i]};
                rem_reg[i] <= ge[i] ? DIV_W'(trial[i] - {1'b0, dsr_reg[i]})
                                    : trial[i][DIV_W-1:0];
            end
        end
    end

    // scan pointer
    logic [CW-1:0] ptr_col_reg;
    logic [RW-1:0] ptr_row_reg;
    logic          row_wrap, col_wrap;

    assign row_wrap = (RCW'(ptr_row_reg) + RCW'(1)) >= h_eff;
    assign col_wrap = (CCW'(ptr_col_reg) + CCW'(1)) >= w_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_col_reg <= '0;
            ptr_row_reg <= '0;
        end
        else if (cmd.wrap_ptr)
        begin
            if ((CCW'(ptr_col_reg) >= w_eff) || (RCW'(ptr_row_reg) >= h_eff))
            begin
                ptr_col_reg <= '0;
                ptr_row_reg <= '0;
            end
        end
        else if (cmd.advance_ptr)
        begin
            if (row_wrap)
            begin
                ptr_row_reg <= '0;
                ptr_col_reg <= col_wrap ? '0 : ptr_col_reg + CW'(1);
            end
            else
            begin
                ptr_row_reg <= ptr_row_reg + RW'(1);
            end
        end
    end

    // brush counters
    logic [2:0]           bx_reg, by_reg;
    logic signed [SW-1:0] xs, ys, xlim, ylim;
    logic                 br_in;

    assign xs    = $signed(SW'(quo_reg[0][PIX_W-1:0])) + $signed(SW'(bx_reg)) - SW'(2);
    assign ys    = $signed(SW'(quo_reg[1][PIX_W-1:0])) + $signed(SW'(by_reg)) - SW'(2);
    assign xlim  = $signed(SW'(w_eff)) - SW'(2);
    assign ylim  = $signed(SW'(h_eff)) - SW'(1);
    assign br_in = !((xs < 0) || (xs > xlim) || (ys < 0) || (ys > ylim));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bx_reg <= '0;
            by_reg <= '0;
        end
        else if (cmd.brush_init)
        begin
            bx_reg <= '0;
            by_reg <= '0;
        end
        else if (cmd.brush_step)
        begin
            if (br_in && (by_reg != BR_LAST))
            begin
                by_reg <= by_reg + 3'd1;
            end
            else
            begin
                bx_reg <= bx_reg + 3'd1;
                by_reg <= '0;
            end
        end
    end

    // row sweep for clears and base row fills
    logic [CCW-1:0]    sw_col_reg, sw_cend_reg;
    logic [RCW-1:0]    sw_row_reg, sw_rend_reg;
    logic [HEAT_W-1:0] sw_data_reg;
    logic              sw_cwrap, sw_we;

    assign sw_cwrap = ({1'b0, sw_col_reg} + (CCW+1)'(1)) >= {1'b0, sw_cend_reg};
    assign sw_we    = cmd.sweep_step && (sw_col_reg < sw_cend_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_col_reg  <= '0;
            sw_row_reg  <= '0;
            sw_cend_reg <= '0;
            sw_rend_reg <= '0;
            sw_data_reg <= '0;
        end
        else if (cmd.sweep_init)
        begin
            sw_col_reg <= '0;
            case (cmd.sweep_kind)
                SW_ALL:
                begin
                    sw_row_reg  <= '0;
                    sw_rend_reg <= RCW'(MAX_ROWS);
                    sw_cend_reg <= CCW'(MAX_COLS);
                    sw_data_reg <= '0;
                end
                SW_CLEAR:
                begin
                    sw_row_reg  <= '0;
                    sw_rend_reg <= h_eff;
                    sw_cend_reg <= w_eff;
                    sw_data_reg <= '0;
                end
                SW_HOT:
                begin
                    sw_row_reg  <= h_eff - RCW'(1);
                    sw_rend_reg <= h_eff;
                    sw_cend_reg <= w_eff - CCW'(1);
                    sw_data_reg <= hot_reg;
                end
                default:
                begin
                    sw_row_reg  <= h_eff - RCW'(1);
                    sw_rend_reg <= h_eff;
                    sw_cend_reg <= w_eff;
                    sw_data_reg <= '0;
                end
            endcase
        end
        else if (cmd.sweep_step)
        begin
            if (sw_cwrap)
            begin
                sw_col_reg <= '0;
                sw_row_reg <= sw_row_reg + RCW'(1);
            end
            else
            begin
                sw_col_reg <= sw_col_reg + CCW'(1);
            end
        end
    end

    // grid memory
    logic              ram_we;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [HEAT_W-1:0] ram_wdata, ram_rdata, loss_up, loss_left, heat_up, heat_left;
    logic              gate_up, gate_left;

    assign loss_up   = HEAT_W'(rem_reg[0]);
    assign loss_left = HEAT_W'(rem_reg[1]);
    assign heat_up   = (loss_up >= ram_rdata) ? '0 : ram_rdata - loss_up;
    assign heat_left = (loss_left >= ram_rdata) ? '0 : ram_rdata - loss_left;
    assign gate_up   = (pct_up < RAND_W'(cu_reg)) && (ptr_row_reg != '0);
    assign gate_left = (pct_left < RAND_W'(cl_reg)) && (ptr_row_reg != '0)
                       && (ptr_col_reg != '0);

    assign ram_raddr = (func_reg == F_READ) ? {RW'(crow_reg), CW'(ccol_reg)}
                                            : {ptr_row_reg, ptr_col_reg};

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = {sw_row_reg[RW-1:0], sw_col_reg[CW-1:0]};
        ram_wdata = sw_data_reg;
        if (cmd.sweep_step)
        begin
            ram_we = sw_we;
        end
        else if (cmd.brush_step)
        begin
            ram_we    = br_in;
            ram_waddr = {ys[RW-1:0], xs[CW-1:0]};
            ram_wdata = hot_reg;
        end
        else if (cmd.wr_up)
        begin
            ram_we    = gate_up;
            ram_waddr = {ptr_row_reg - RW'(1), ptr_col_reg};
            ram_wdata = heat_up;
        end
        else if (cmd.wr_left)
        begin
            ram_we    = gate_left;
            ram_waddr = {ptr_row_reg - RW'(1), ptr_col_reg - CW'(1)};
            ram_wdata = heat_left;
        end
    end

    fgp_ram #(
        .WIDTH (HEAT_W),
        .DEPTH (MAX_ROWS << CW)
    ) u_grid (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // result and output word
    logic [HEAT_W-1:0] res_val_reg, out_val_reg;
    logic [IDX_W-1:0]  res_col_reg, res_row_reg, out_col_reg, out_row_reg;
    logic              res_done_reg, out_done_reg, out_valid_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            res_val_reg  <= '0;
            res_col_reg  <= '0;
            res_row_reg  <= '0;
            res_done_reg <= 1'b0;
        end
        else if (cmd.advance_ptr)
        begin
            res_col_reg  <= IDX_W'(ptr_col_reg);
            res_row_reg  <= IDX_W'(ptr_row_reg);
            res_done_reg <= row_wrap && col_wrap;
        end
        else if (cmd.set_read)
        begin
            res_val_reg <= ((ccol_reg < w_eff) && (crow_reg < h_eff)) ? ram_rdata : '0;
        end
        if (cmd.out_load)
        begin
            out_val_reg  <= res_val_reg;
            out_col_reg  <= res_col_reg;
            out_row_reg  <= res_row_reg;
            out_done_reg <= res_done_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign cell_value = out_val_reg;
    assign scan_col   = out_col_reg;
    assign scan_row   = out_row_reg;
    assign frame_done = out_done_reg;

    assign stat.func       = func_reg;
    assign stat.div_done   = (dcnt_reg == '0);
    assign stat.brush_last = (bx_reg == BR_LAST) && (!br_in || (by_reg == BR_LAST));
    assign stat.sweep_last = sw_cwrap && ((sw_row_reg + RCW'(1)) >= sw_rend_reg);
    assign stat.out_free   = !out_valid_reg || !out_stall;

endmodule

@@ hw/rtl/fgp_ctrl.sv @@
// ----------------------------------------------------------------------------
// fgp_ctrl
// Sequencer: clearing pass after reset, per-function command sequences and
// hand-off to the output word.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fgp_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  fgp_pkg::stat_t stat,
    output fgp_pkg::cmd_t  cmd
);
    import fgp_pkg::*;

    localparam logic [3:0] S_INIT   = 4'd0;
    localparam logic [3:0] S_INITSW = 4'd1;
    localparam logic [3:0] S_IDLE   = 4'd2;
    localparam logic [3:0] S_DECODE = 4'd3;
    localparam logic [3:0] S_DIV    = 4'd4;
    localparam logic [3:0] S_WUP    = 4'd5;
    localparam logic [3:0] S_WLEFT  = 4'd6;
    localparam logic [3:0] S_READ   = 4'd7;
    localparam logic [3:0] S_BRUSH  = 4'd8;
    localparam logic [3:0] S_SWEEP  = 4'd9;
    localparam logic [3:0] S_OUT    = 4'd10;

    logic [3:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_INIT:
            begin
                cmd.sweep_init = 1'b1;
                cmd.sweep_kind = SW_ALL;
                state_next     = S_INITSW;
            end
            S_INITSW:
            begin
                cmd.sweep_step = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (stat.func)
                    F_PROP:
                    begin
                        cmd.wrap_ptr  = 1'b1;
                        cmd.div_start = 1'b1;
                        state_next    = S_DIV;
                    end
                    F_BRUSH:
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = S_DIV;
                    end
                    F_READ:
                    begin
                        state_next = S_READ;
                    end
                    F_HOT:
                    begin
                        cmd.sweep_init = 1'b1;
                        cmd.sweep_kind = SW_HOT;
                        state_next     = S_SWEEP;
                    end
                    F_CLEAR:
                    begin
                        cmd.sweep_init = 1'b1;
                        cmd.sweep_kind = SW_CLEAR;
                        state_next     = S_SWEEP;
                    end
                    F_ZERO:
                    begin
                        cmd.sweep_init = 1'b1;
                        cmd.sweep_kind = SW_ZERO;
                        state_next     = S_SWEEP;
                    end
                    default:
                    begin
                        state_next = S_OUT;
                    end
                endcase
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    if (stat.func == F_BRUSH)
                    begin
                        cmd.brush_init = 1'b1;
                        state_next     = S_BRUSH;
                    end
                    else
                    begin
                        state_next = S_WUP;
                    end
                end
            end
            S_WUP:
            begin
                cmd.wr_up  = 1'b1;
                state_next = S_WLEFT;
            end
            S_WLEFT:
            begin
                cmd.wr_left     = 1'b1;
                cmd.advance_ptr = 1'b1;
                state_next      = S_OUT;
            end
            S_READ:
            begin
                cmd.set_read = 1'b1;
                state_next   = S_OUT;
            end
            S_BRUSH:
            begin
                cmd.brush_step = 1'b1;
                if (stat.brush_last)
                begin
                    state_next = S_OUT;
                end
            end
            S_SWEEP:
            begin
                cmd.sweep_step = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `FGP_ASSERT(a_load_free, cmd.out_load |-> stat.out_free)
    `FGP_ASSERT(a_one_write, $onehot0({cmd.wr_up, cmd.wr_left, cmd.brush_step, cmd.sweep_step}))
    `FGP_ASSERT_NEXT(a_up_then_left, cmd.wr_up, cmd.wr_left && cmd.advance_ptr)
    `FGP_ASSERT(a_no_accept_busy, cmd.accept |-> !$past(cmd.sweep_step) || $past(stat.sweep_last))

endmodule

@@ hw/rtl/fire_grid_propagation_top.sv @@
// ----------------------------------------------------------------------------
// fire_grid_propagation_top
// Heat grid for a fire effect: propagate, read, brush, base row and clear.
// ----------------------------------------------------------------------------
//  channel   handshake               payload
//  input     in_valid / in_stall     func, pixel_x/y, cell_col/row, rand_*
//  output    out_valid / out_stall   cell_value, scan_col, scan_row, frame_done
//  config    cfg_write               cfg_index, cfg_data
//
//  Steps from accept to output word. Propagate: 15-step remainder lanes,
//  then the up write and the left write. Read: one grid read. Brush: the
//  remainder lanes, then one brush cell per cycle. Clear, zero base and
//  set base hot sweep their cells. Unused codes go straight to output.
//  After reset the grid memory is cleared.
//  One word at a time; the next is taken while a result waits on out_stall.
// ----------------------------------------------------------------------------
module fire_grid_propagation_top #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [fgp_pkg::CFG_IX_W-1:0]   cfg_index,
    input  logic [fgp_pkg::CFG_W-1:0]      cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [fgp_pkg::FUNC_W-1:0]     func,
    input  logic [fgp_pkg::PIX_W-1:0]      pixel_x,
    input  logic [fgp_pkg::PIX_W-1:0]      pixel_y,
    input  logic [fgp_pkg::IDX_W-1:0]      cell_col,
    input  logic [fgp_pkg::IDX_W-1:0]      cell_row,
    input  logic [fgp_pkg::RAND_W-1:0]     rand_up_gate,
    input  logic [fgp_pkg::RAND_W-1:0]     rand_up_drop,
    input  logic [fgp_pkg::RAND_W-1:0]     rand_left_gate,
    input  logic [fgp_pkg::RAND_W-1:0]     rand_left_drop,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [fgp_pkg::HEAT_W-1:0]     cell_value,
    output logic [fgp_pkg::IDX_W-1:0]      scan_col,
    output logic [fgp_pkg::IDX_W-1:0]      scan_row,
    output logic                           frame_done
);
    import fgp_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    fgp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    fgp_datapath #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .func           (func),
        .pixel_x        (pixel_x),
        .pixel_y        (pixel_y),
        .cell_col       (cell_col),
        .cell_row       (cell_row),
        .rand_up_gate   (rand_up_gate),
        .rand_up_drop   (rand_up_drop),
        .rand_left_gate (rand_left_gate),
        .rand_left_drop (rand_left_drop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .cell_value     (cell_value),
        .scan_col       (scan_col),
        .scan_row       (scan_row),
        .frame_done     (frame_done),
        .cmd            (cmd),
        .stat           (stat)
    );

endmodule

@@ verif/fire_grid_propagation_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fire_grid_propagation_checker
// Watches the input, output and register-write ports of the heat grid block,
// keeps its own copy of the grid, scan position and registers, predicts the
// result of every accepted word and compares it field by field.
// ----------------------------------------------------------------------------
module fire_grid_propagation_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [fgp_pkg::CFG_IX_W-1:0]   cfg_index,
    input  logic [fgp_pkg::CFG_W-1:0]      cfg_data,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic [fgp_pkg::FUNC_W-1:0]     func,
    input  logic [fgp_pkg::PIX_W-1:0]      pixel_x,
    input  logic [fgp_pkg::PIX_W-1:0]      pixel_y,
    input  logic [fgp_pkg::IDX_W-1:0]      cell_col,
    input  logic [fgp_pkg::IDX_W-1:0]      cell_row,
    input  logic [fgp_pkg::RAND_W-1:0]     rand_up_gate,
    input  logic [fgp_pkg::RAND_W-1:0]     rand_up_drop,
    input  logic [fgp_pkg::RAND_W-1:0]     rand_left_gate,
    input  logic [fgp_pkg::RAND_W-1:0]     rand_left_drop,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic [fgp_pkg::HEAT_W-1:0]     cell_value,
    input  logic [fgp_pkg::IDX_W-1:0]      scan_col,
    input  logic [fgp_pkg::IDX_W-1:0]      scan_row,
    input  logic                           frame_done,
    output int                             errors,
    output int                             pending
);
    import fgp_pkg::*;

    localparam int NC = 64;
    localparam int NR = 64;

    typedef struct packed {
        logic [HEAT_W-1:0] value;
        logic [IDX_W-1:0]  col;
        logic [IDX_W-1:0]  row;
        logic              done;
    } heat_result_t;

    logic [HEAT_W-1:0] grid [NR][NC];
    int unsigned col_ptr, row_ptr;
    logic [CFG_W-1:0] g_width, g_height, c_size, ch_up, ch_left, hot_lvl;
    logic [DEC_W-1:0] dec_up, dec_left;
    heat_result_t expected_q[$];

    assign pending = expected_q.size();

    function automatic logic [HEAT_W-1:0] cooled(logic [HEAT_W-1:0] heat,
                                                 logic [RAND_W-1:0] draw,
                                                 logic [DEC_W-1:0] decay);
        int unsigned m;
        int unsigned loss;
        m = (decay == 0) ? 1 : decay;
        loss = draw % m;
        return (loss >= heat) ? '0 : HEAT_W'(heat - loss);
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task automatic predict_word();
        heat_result_t res;
        int w, h, cs, cx, cy, x, y;
        int unsigned c, r;
        logic [HEAT_W-1:0] cur;
        res = '0;
        w = (g_width == 0) ? 1 : ((g_width > NC) ? NC : g_width);
        h = (g_height == 0) ? 1 : ((g_height > NR) ? NR : g_height);
        case (func)
            F_PROP:
            begin
                if (col_ptr >= w || row_ptr >= h)
                begin
                    col_ptr = 0;
                    row_ptr = 0;
                end
                c = col_ptr;
                r = row_ptr;
                cur = grid[r][c];
                if (rand_up_gate % 100 < ch_up && r > 0)
                    grid[r-1][c] = cooled(cur, rand_up_drop, dec_up);
                if (rand_left_gate % 100 < ch_left && c > 0 && r > 0)
                    grid[r-1][c-1] = cooled(cur, rand_left_drop, dec_left);
                res.col = IDX_W'(c);
                res.row = IDX_W'(r);
                r++;
                if (r >= h)
                begin
                    r = 0;
                    c++;
                    if (c >= w)
                    begin
                        c = 0;
                        res.done = 1'b1;
                    end
                end
                col_ptr = c;
                row_ptr = r;
            end
            F_READ:
                if (cell_col < w && cell_row < h)
                    res.value = grid[cell_row][cell_col];
            F_BRUSH:
            begin
                cs = (c_size == 0) ? 1 : c_size;
                cx = pixel_x / cs;
                cy = pixel_y / cs;
                for (int dx = -2; dx < 3; dx++)
                    for (int dy = -2; dy < 3; dy++)
                    begin
                        x = cx + dx;
                        y = cy + dy;
                        if (x < 0 || x > w - 2 || y < 0 || y > h - 1)
                            break;
                        grid[y][x] = hot_lvl;
                    end
            end
            F_HOT:
                for (x = 0; x < w - 1; x++)
                    grid[h-1][x] = hot_lvl;
            F_CLEAR:
                for (y = 0; y < h; y++)
                    for (x = 0; x < w; x++)
                        grid[y][x] = '0;
            F_ZERO:
                for (x = 0; x < w; x++)
                    grid[h-1][x] = '0;
            default:
                ;
        endcase
        expected_q = {expected_q, res};
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (grid[i, j])
                grid[i][j] = '0;
            col_ptr = 0;
            row_ptr = 0;
            g_width = RST_GRID_WIDTH;
            g_height = RST_GRID_HEIGHT;
            c_size = RST_CELL_SIZE;
            ch_up = RST_CHANCE_UP;
            ch_left = RST_CHANCE_LEFT;
            dec_up = RST_DECAY_UP;
            dec_left = RST_DECAY_LEFT;
            hot_lvl = RST_HOTTEST;
            expected_q.delete();
            errors = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("unexpected word at %0t", $realtime);
                    errors++;
                end
                else
                begin
                    heat_result_t e;
                    e = expected_q.pop_front();
                    if (cell_value !== e.value) report("cell_value", cell_value, e.value);
                    if (scan_col !== e.col) report("scan_col", scan_col, e.col);
                    if (scan_row !== e.row) report("scan_row", scan_row, e.row);
                    if (frame_done !== e.done) report("frame_done", frame_done, e.done);
                end
            end
            if (cfg_write)
                case (cfg_index)
                    REG_GRID_WIDTH:  g_width = cfg_data;
                    REG_GRID_HEIGHT: g_height = cfg_data;
                    REG_CELL_SIZE:   c_size = cfg_data;
                    REG_CHANCE_UP:   ch_up = cfg_data;
                    REG_CHANCE_LEFT: ch_left = cfg_data;
                    REG_DECAY_UP:    dec_up = cfg_data[DEC_W-1:0];
                    REG_DECAY_LEFT:  dec_left = cfg_data[DEC_W-1:0];
                    REG_HOTTEST:     hot_lvl = cfg_data;
                    default: ;
                endcase
            if (in_valid && !in_stall)
                predict_word();
        end
    end
endmodule

@@ verif/fire_grid_propagation_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fire_grid_propagation_top_tb
// Drives directed and random words through the heat grid block under random
// gaps and stalls on both sides, across several register settings, and gives
// a verdict from the checker's mismatch and pending counts.
// ----------------------------------------------------------------------------
module fire_grid_propagation_top_tb;
    import fgp_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [CFG_IX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [FUNC_W-1:0] func = '0;
    logic [PIX_W-1:0] pixel_x = '0, pixel_y = '0;
    logic [IDX_W-1:0] cell_col = '0, cell_row = '0;
    logic [RAND_W-1:0] rand_up_gate = '0, rand_up_drop = '0;
    logic [RAND_W-1:0] rand_left_gate = '0, rand_left_drop = '0;
    logic out_valid;
    logic out_stall = 1'b1;
    logic [HEAT_W-1:0] cell_value;
    logic [IDX_W-1:0] scan_col, scan_row;
    logic frame_done;
    int errors, pending;
    int cycles = 0;
    bit hold_off = 1'b0;
    bit sink_free = 1'b0;

    localparam int LIMIT = 3000000;

    always #5 clk = ~clk;

    fire_grid_propagation_top DUT (.*);
    fire_grid_propagation_checker CHK (.*);

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("timeout");
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // receiver: random stalls, plus one long hold-off
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                out_stall <= 1'b1;
                for (int i = 0; i < 400; i++) @(negedge clk);
                hold_off = 1'b0;
            end
            if (sink_free)
            begin
                out_stall <= 1'b0;
            end
            else
            begin
                n = gap_len();
                out_stall <= (n != 0);
                for (int i = 1; i < n; i++) @(negedge clk);
            end
        end
    end

    task automatic write_reg(logic [CFG_IX_W-1:0] ix, int val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= ix;
        cfg_data <= CFG_W'(val);
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic send_word(logic [FUNC_W-1:0] f, int px, int py, int cc, int cr,
                             int ug, int ud, int lg, int ld, bit nogap = 0);
        int n;
        n = nogap ? 0 : gap_len();
        @(negedge clk);
        for (int i = 0; i < n; i++) @(negedge clk);
        func <= f;
        pixel_x <= PIX_W'(px);
        pixel_y <= PIX_W'(py);
        cell_col <= IDX_W'(cc);
        cell_row <= IDX_W'(cr);
        rand_up_gate <= RAND_W'(ug);
        rand_up_drop <= RAND_W'(ud);
        rand_left_gate <= RAND_W'(lg);
        rand_left_drop <= RAND_W'(ld);
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic rand_word(int weight_prop);
        int p;
        logic [FUNC_W-1:0] f;
        p = $urandom_range(0, 99);
        if (p < weight_prop) f = F_PROP;
        else if (p < weight_prop + 20) f = F_READ;
        else if (p < weight_prop + 28) f = F_BRUSH;
        else if (p < weight_prop + 31) f = F_HOT;
        else if (p < weight_prop + 33) f = F_ZERO;
        else if (p < weight_prop + 34) f = F_CLEAR;
        else f = ($urandom_range(0, 1) == 0) ? F_RSVD6 : F_RSVD7;
        send_word(f, $urandom_range(0, 4095),
                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 600),
                  $urandom_range(0, 63), $urandom_range(0, 63),
                  $urandom_range(0, 32767), $urandom_range(0, 32767),
                  $urandom_range(0, 32767), $urandom_range(0, 32767));
    endtask

    task automatic settle();
        while (pending != 0) @(posedge clk);
        // extra idle time after the last expected word has been taken
        repeat (4200) @(posedge clk);
    endtask

    task automatic load_setting(int w, int h, int cs, int cu, int cl, int du, int dl, int hl);
        write_reg(REG_GRID_WIDTH, w);
        write_reg(REG_GRID_HEIGHT, h);
        write_reg(REG_CELL_SIZE, cs);
        write_reg(REG_CHANCE_UP, cu);
        write_reg(REG_CHANCE_LEFT, cl);
        write_reg(REG_DECAY_UP, du);
        write_reg(REG_DECAY_LEFT, dl);
        write_reg(REG_HOTTEST, hl);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (4200) @(posedge clk);

        // directed: small grid, each function and the field extremes
        load_setting(6, 5, 4, 100, 100, 10, 1, 127);
        send_word(F_HOT, 0, 0, 0, 0, 0, 0, 0, 0);
        send_word(F_BRUSH, 0, 0, 0, 0, 0, 0, 0, 0);
        send_word(F_BRUSH, 4095, 4095, 0, 0, 0, 0, 0, 0);
        send_word(F_BRUSH, 12, 8, 0, 0, 0, 0, 0, 0);
        for (int i = 0; i < 8; i++)
            send_word(F_PROP, 0, 0, 0, 0, 32767, 32767, 0, 9);
        send_word(F_READ, 0, 0, 63, 63, 0, 0, 0, 0);
        send_word(F_READ, 0, 0, 2, 3, 0, 0, 0, 0);
        send_word(F_READ, 0, 0, 6, 0, 0, 0, 0, 0);
        send_word(F_RSVD6, 4095, 4095, 63, 63, 32767, 32767, 32767, 32767);
        send_word(F_RSVD7, 0, 0, 0, 0, 0, 0, 0, 0);
        send_word(F_ZERO, 0, 0, 0, 0, 0, 0, 0, 0);
        send_word(F_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);
        settle();

        // shrink grid with scan pointer beyond it; zero width, height, cell size and decays count as one
        load_setting(0, 0, 0, 127, 0, 0, 0, 0);
        send_word(F_PROP, 0, 0, 0, 0, 0, 0, 0, 0);
        send_word(F_BRUSH, 5, 5, 0, 0, 0, 0, 0, 0);
        send_word(F_READ, 0, 0, 0, 0, 0, 0, 0, 0);
        settle();

        // long receiver hold-off while words keep coming
        load_setting(64, 64, 8, 70, 40, 2, 3, 36);
        hold_off = 1'b1;
        for (int i = 0; i < 30; i++)
            send_word(F_READ, 0, 0, i, i, 0, 0, 0, 0, 1);
        settle();

        // random phases across settings
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: load_setting(8, 8, 2, 70, 40, 2, 3, 36);
                1: load_setting(1, 1, 1, 0, 0, 1, 1, 0);
                2: load_setting(127, 127, 127, 127, 127, 15, 15, 127);
                3: load_setting(16, 3, 64, 50, 90, 10, 10, 100);
                4: load_setting($urandom_range(2, 12), $urandom_range(2, 12),
                                $urandom_range(1, 64), $urandom_range(0, 100),
                                $urandom_range(0, 100), $urandom_range(1, 10),
                                $urandom_range(1, 10), $urandom_range(0, 127));
                default: load_setting(20, 10, 8, 100, 60, 4, 7, 90);
            endcase
            for (int i = 0; i < 300; i++)
                rand_word(ph == 2 ? 40 : 55);
            settle();
        end

        sink_free = 1'b1;
        repeat (50) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
